// ----- src/ucd_pkg.sv -----
// Shared types, constants and byte-level helpers for the UTF-8 code point decoder.
// No dependencies; every other file in src imports this package.
package ucd_pkg;

    localparam int CP_W = 21;
    localparam int MAX_RES = 3;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;
    localparam logic [CP_W-1:0] CP_VS16        = 21'h00fe0f;
    localparam logic [CP_W-1:0] CP_VS15        = 21'h00fe0e;
    localparam logic [CP_W-1:0] CP_ZWJ         = 21'h00200d;

    // Sequence lengths implied by a lead byte
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code_point;
        logic            last;
    } ucd_res_t;

    // Up to three results produced by one item, packed from entry 0
    typedef struct packed {
        ucd_res_t [MAX_RES-1:0] res;
        logic [1:0]             cnt;
    } ucd_set_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = LEN_1;
        end else if ((b & 8'he0) == 8'hc0) begin
            len = LEN_2;
        end else if ((b & 8'hf0) == 8'he0) begin
            len = LEN_3;
        end else if ((b & 8'hf8) == 8'hf0) begin
            len = LEN_4;
        end else begin
            len = LEN_BAD;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                                 input logic [7:0] b2, input logic [7:0] b3,
                                                 input logic [2:0] len);
        logic [CP_W-1:0] cp;
        unique case (len)
            LEN_2: cp = {10'd0, b0[4:0], b1[5:0]};
            LEN_3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            LEN_4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = CP_REPLACEMENT;
        endcase
        return cp;
    endfunction

    // A byte standing alone: ASCII passes, anything else is a replacement
    function automatic logic [CP_W-1:0] single(input logic [7:0] b);
        return b[7] ? CP_REPLACEMENT : {13'd0, b};
    endfunction

    function automatic logic is_dropped(input logic [CP_W-1:0] cp);
        return (cp == CP_VS16) || (cp == CP_VS15) || (cp == CP_ZWJ);
    endfunction

endpackage

// ----- src/ucd_step.sv -----
// Per-item decode: pending sequence state plus the combinational step that turns
// one byte into a packed set of results. Depends on ucd_pkg.
module ucd_step import ucd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output ucd_set_t   set
);

    logic [7:0] pend_reg [3];
    logic [1:0] pcount_reg, pcount_next;
    logic [2:0] seqlen_reg, seqlen_next;
    logic       wr_en;

    logic [7:0]      bytes_w [4];
    logic [CP_W-1:0] cand_cp [MAX_RES];
    logic            cand_v  [MAX_RES];
    logic [2:0]      pc_plus;
    logic [2:0]      len_w;

    assign pc_plus = {1'b0, pcount_reg} + 3'd1;
    assign len_w   = lead_len(data_byte);

    // Held bytes with the new byte placed right after them
    assign bytes_w[0] = (pcount_reg == 2'd0) ? data_byte : pend_reg[0];
    assign bytes_w[1] = (pcount_reg == 2'd1) ? data_byte : pend_reg[1];
    assign bytes_w[2] = (pcount_reg == 2'd2) ? data_byte : pend_reg[2];
    assign bytes_w[3] = data_byte;

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            cand_cp[i] = CP_REPLACEMENT;
            cand_v[i]  = 1'b0;
        end
        pcount_next = pcount_reg;
        seqlen_next = seqlen_reg;
        wr_en       = 1'b0;
        if (end_of_string) begin
            pcount_next = 2'd0;
            seqlen_next = 3'd0;
            cand_v[0]   = 1'b1;
            if (pcount_reg == 2'd0) begin
                cand_cp[0] = single(data_byte);
            end else if (pc_plus == seqlen_reg) begin
                cand_cp[0] = assemble(bytes_w[0], bytes_w[1], bytes_w[2], bytes_w[3],
                                      seqlen_reg);
            end else begin
                // unfinished lead; bytes after it are decoded again as leads
                cand_cp[0] = CP_REPLACEMENT;
                cand_v[1]  = 1'b1;
                if (pcount_reg == 2'd1) begin
                    cand_cp[1] = single(bytes_w[1]);
                end else if (lead_len(bytes_w[1]) == LEN_2) begin
                    cand_cp[1] = assemble(bytes_w[1], bytes_w[2], 8'd0, 8'd0, LEN_2);
                end else begin
                    cand_cp[1] = single(bytes_w[1]);
                    cand_cp[2] = single(bytes_w[2]);
                    cand_v[2]  = 1'b1;
                end
            end
        end else if (pcount_reg == 2'd0) begin
            if (len_w == LEN_1) begin
                cand_cp[0] = single(data_byte);
                cand_v[0]  = 1'b1;
            end else if (len_w == LEN_BAD) begin
                cand_cp[0] = CP_REPLACEMENT;
                cand_v[0]  = 1'b1;
            end else begin
                wr_en       = 1'b1;
                pcount_next = 2'd1;
                seqlen_next = len_w;
            end
        end else if (pc_plus >= seqlen_reg || pcount_reg == 2'd3) begin
            cand_cp[0]  = assemble(bytes_w[0], bytes_w[1], bytes_w[2], bytes_w[3],
                                   (pc_plus == seqlen_reg) ? seqlen_reg : LEN_BAD);
            cand_v[0]   = 1'b1;
            pcount_next = 2'd0;
            seqlen_next = 3'd0;
        end else begin
            wr_en       = 1'b1;
            pcount_next = pc_plus[1:0];
        end
    end

    // Drop filtered code points, pack the rest, mark the end of the string
    always_comb begin
        logic [1:0] k;
        k   = 2'd0;
        set = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (cand_v[i] && !is_dropped(cand_cp[i])) begin
                set.res[k].code_point     = cand_cp[i];
                set.res[k].has_code_point = 1'b1;
                k = k + 2'd1;
            end
        end
        if (end_of_string) begin
            if (k == 2'd0) begin
                set.res[0].last = 1'b1;
                k = 2'd1;
            end else begin
                set.res[k - 2'd1].last = 1'b1;
            end
        end
        set.cnt = k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= 2'd0;
            seqlen_reg <= 3'd0;
        end else if (advance) begin
            pcount_reg <= pcount_next;
            seqlen_reg <= seqlen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && wr_en) begin
            pend_reg[pcount_reg] <= data_byte;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg != 2'd0) |-> ({1'b0, pcount_reg} < seqlen_reg))
        else $error("pending count reached sequence length");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg == 2'd0) |-> (seqlen_reg == 3'd0))
        else $error("sequence length left without pending lead");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && end_of_string) |=> (pcount_reg == 2'd0))
        else $error("pending state not cleared at string end");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !end_of_string) |-> (set.cnt <= 2'd1))
        else $error("more than one result for a mid-string byte");
`endif

endmodule

// ----- src/ucd_result_queue.sv -----
// Result register: holds up to three results of one item and hands them out
// one per cycle on the m_ channel while m_ready is high. Depends on ucd_pkg.
module ucd_result_queue import ucd_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  ucd_set_t        set,
    output logic            free,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_has_code_point,
    output logic            m_last
);

    ucd_res_t   q_reg [MAX_RES];
    logic [1:0] count_reg;
    logic       pop;

    assign m_valid          = (count_reg != 2'd0);
    assign pop              = m_valid && m_ready;
    assign free             = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign m_code_point     = q_reg[0].code_point;
    assign m_has_code_point = q_reg[0].has_code_point;
    assign m_last           = q_reg[0].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load) begin
            count_reg <= set.cnt;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                q_reg[i] <= set.res[i];
            end
        end else if (pop) begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("result set loaded over undelivered results");
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (count_reg == $past(set.cnt)))
        else $error("result count not taken from loaded set");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > 2'd1) |-> !q_reg[0].last)
        else $error("last mark ahead of further results");
`endif

endmodule

// ----- src/utf8_codepoint_decoder.sv -----
// UTF-8 code point decoder: one byte per input item, code points out.
// Instantiates ucd_step and ucd_result_queue; depends on ucd_pkg.
//
// One byte is taken per cycle unless the input stalls, and each byte is decoded in a single
// pass from the input register into the result register, so the first result of a byte
// reaches m_ at the earliest through the input register and then the result register. Bytes
// that give zero or one result sustain one item per cycle while m_ready is high. A byte
// flagged end_of_string can give up to three results; they leave the result register one
// per cycle while m_ready is high, and a following byte that gives a result waits until the
// last of them is being taken. Sequences are not validated beyond the lead byte; U+FE0F,
// U+FE0E and U+200D are removed from the stream, and if that leaves nothing for the end of
// a string, a result with has_code_point low and last high closes it.
module utf8_codepoint_decoder import ucd_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_end_of_string,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_has_code_point,
    output logic            m_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       advance;
    logic       free;
    ucd_set_t   set;

    // An item moves on when its results fit, or when it has none
    assign advance = in_valid_reg && ((set.cnt == 2'd0) || free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    ucd_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .end_of_string (in_eos_reg),
        .set           (set)
    );

    ucd_result_queue u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance && (set.cnt != 2'd0)),
        .set              (set),
        .free             (free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_point     (m_code_point),
        .m_has_code_point (m_has_code_point),
        .m_last           (m_last)
    );

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_eos_reg) |-> (set.cnt != 2'd0))
        else $error("string end produced no result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_ready)
        else $error("input taken while held item is stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input item lost or changed");
`endif

endmodule
